// ----- hw/rtl/lbps_pkg.sv -----
// Package for the light bar pattern sequencer.
// Holds the state record, the reset constants and the pattern step tables.
// No dependencies.
package lbps_pkg;

	localparam int unsigned DEBOUNCE_W = 9;
	localparam int unsigned SINCE_W    = 9;
	localparam int unsigned TIMER_W    = 9;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned MODE_W     = 4;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned LAMPS_W    = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 9'd180;
	localparam logic [SINCE_W-1:0]    SINCE_MAX      = 9'd511;

	localparam logic [MODE_W-1:0] MODE_OFF    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_STATIC = 4'd1;
	localparam logic [MODE_W-1:0] MODE_LAST   = 4'd8;

	localparam logic [LAMPS_W-1:0] LAMPS_STATIC = 16'h000F;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic               prev_button;
		logic [SINCE_W-1:0] since_press;
		logic [INDEX_W-1:0] step_index;
		logic [TIMER_W-1:0] step_timer;
	} lbps_state_t;

	localparam lbps_state_t STATE_RESET = '{
		mode:        MODE_OFF,
		prev_button: 1'b1,
		since_press: '0,
		step_index:  '0,
		step_timer:  '0
	};

	typedef struct packed {
		logic [LAMPS_W-1:0] lamps;
		logic [TIMER_W-1:0] ticks;
	} lbps_step_t;

	function automatic logic [POS_W-1:0] mode_start(input logic [MODE_W-1:0] mode);
		logic [POS_W-1:0] s;
		unique case (mode)
			4'd3:    s = 6'd2;
			4'd4:    s = 6'd12;
			4'd5:    s = 6'd26;
			4'd6:    s = 6'd34;
			4'd7:    s = 6'd42;
			4'd8:    s = 6'd52;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	function automatic logic [INDEX_W-1:0] mode_len(input logic [MODE_W-1:0] mode);
		logic [INDEX_W-1:0] n;
		unique case (mode)
			4'd2:    n = 4'd2;
			4'd3:    n = 4'd10;
			4'd4:    n = 4'd14;
			4'd5:    n = 4'd8;
			4'd6:    n = 4'd8;
			4'd7:    n = 4'd10;
			4'd8:    n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic lbps_step_t step_entry(input logic [POS_W-1:0] pos);
		lbps_step_t e;
		unique case (pos)
			6'd0:  e = '{16'h0F35, 9'd450};
			6'd1:  e = '{16'hF0CA, 9'd450};
			6'd2:  e = '{16'h0F35, 9'd180};
			6'd3:  e = '{16'h0000, 9'd150};
			6'd4:  e = '{16'h0F35, 9'd180};
			6'd5:  e = '{16'h0000, 9'd150};
			6'd6:  e = '{16'h0000, 9'd200};
			6'd7:  e = '{16'hF0CA, 9'd180};
			6'd8:  e = '{16'h0000, 9'd150};
			6'd9:  e = '{16'hF0CA, 9'd180};
			6'd10: e = '{16'h0000, 9'd150};
			6'd11: e = '{16'h0000, 9'd300};
			6'd12: e = '{16'h0F35, 9'd180};
			6'd13: e = '{16'h0000, 9'd150};
			6'd14: e = '{16'h0F35, 9'd180};
			6'd15: e = '{16'h0000, 9'd150};
			6'd16: e = '{16'h0F35, 9'd180};
			6'd17: e = '{16'h0000, 9'd150};
			6'd18: e = '{16'h0000, 9'd200};
			6'd19: e = '{16'hF0CA, 9'd180};
			6'd20: e = '{16'h0000, 9'd150};
			6'd21: e = '{16'hF0CA, 9'd180};
			6'd22: e = '{16'h0000, 9'd150};
			6'd23: e = '{16'hF0CA, 9'd180};
			6'd24: e = '{16'h0000, 9'd150};
			6'd25: e = '{16'h0000, 9'd300};
			6'd26: e = '{16'h0135, 9'd120};
			6'd27: e = '{16'h10CA, 9'd120};
			6'd28: e = '{16'h0235, 9'd120};
			6'd29: e = '{16'h20CA, 9'd120};
			6'd30: e = '{16'h0435, 9'd120};
			6'd31: e = '{16'h40CA, 9'd120};
			6'd32: e = '{16'h0835, 9'd120};
			6'd33: e = '{16'h80CA, 9'd120};
			6'd34: e = '{16'h0335, 9'd120};
			6'd35: e = '{16'h0635, 9'd120};
			6'd36: e = '{16'h0C35, 9'd120};
			6'd37: e = '{16'h0C35, 9'd80};
			6'd38: e = '{16'h30CA, 9'd120};
			6'd39: e = '{16'h60CA, 9'd120};
			6'd40: e = '{16'hC0CA, 9'd120};
			6'd41: e = '{16'hC0CA, 9'd100};
			6'd42: e = '{16'h0335, 9'd180};
			6'd43: e = '{16'h0000, 9'd140};
			6'd44: e = '{16'h0335, 9'd180};
			6'd45: e = '{16'h0000, 9'd140};
			6'd46: e = '{16'h0000, 9'd200};
			6'd47: e = '{16'hC0CA, 9'd180};
			6'd48: e = '{16'h0000, 9'd140};
			6'd49: e = '{16'hC0CA, 9'd180};
			6'd50: e = '{16'h0000, 9'd140};
			6'd51: e = '{16'h0000, 9'd300};
			6'd52: e = '{16'hFF00, 9'd250};
			6'd53: e = '{16'h0000, 9'd200};
			6'd54: e = '{16'h0003, 9'd220};
			6'd55: e = '{16'h0000, 9'd150};
			6'd56: e = '{16'h000C, 9'd220};
			6'd57: e = '{16'h0000, 9'd200};
			6'd58: e = '{16'hFF00, 9'd250};
			6'd59: e = '{16'h0000, 9'd300};
			default: e = '{16'h0000, 9'd1};
		endcase
		return e;
	endfunction

endpackage

// ----- hw/rtl/lbps_step.sv -----
// Next-state and lamp logic for one tick of the light bar sequencer.
// Depends on lbps_pkg for the state record and the step tables.
module lbps_step (
	input  lbps_pkg::lbps_state_t              state,
	input  logic                               button_level,
	input  logic [lbps_pkg::DEBOUNCE_W-1:0]    debounce_ms,
	output lbps_pkg::lbps_state_t              state_next,
	output logic [lbps_pkg::LAMPS_W-1:0]       lamps
);
	import lbps_pkg::*;

	always_comb begin
		logic [SINCE_W-1:0] since_inc;
		logic               press;
		logic [MODE_W-1:0]  mode_n;
		logic [INDEX_W-1:0] idx0;
		logic [INDEX_W-1:0] idx1;
		logic [INDEX_W-1:0] len;
		logic [TIMER_W-1:0] tmr0;
		logic [TIMER_W-1:0] tmr1;
		logic [POS_W-1:0]   pos;
		lbps_step_t         entry;

		since_inc = (state.since_press == SINCE_MAX) ? state.since_press
			: state.since_press + 9'd1;
		press = !button_level && state.prev_button && (since_inc > debounce_ms);
		mode_n = state.mode;
		if (press) begin
			mode_n = (state.mode >= MODE_LAST) ? MODE_OFF : state.mode + 4'd1;
		end
		idx0 = press ? '0 : state.step_index;
		tmr0 = press ? '0 : state.step_timer;
		len = mode_len(mode_n);
		pos = mode_start(mode_n) + {2'b00, idx0};
		entry = step_entry(pos);
		idx1 = idx0 + 4'd1;
		tmr1 = tmr0 + 9'd1;

		state_next.mode        = mode_n;
		state_next.prev_button = button_level;
		state_next.since_press = press ? '0 : since_inc;
		state_next.step_index  = '0;
		state_next.step_timer  = '0;
		lamps                  = '0;

		if (mode_n == MODE_STATIC) begin
			lamps = LAMPS_STATIC;
		end else if (mode_n > MODE_STATIC && mode_n <= MODE_LAST) begin
			lamps = entry.lamps;
			if (tmr1 >= entry.ticks) begin
				state_next.step_index = (idx1 >= len) ? '0 : idx1;
			end else begin
				state_next.step_index = idx0;
				state_next.step_timer = tmr1;
			end
		end
	end

endmodule

// ----- hw/rtl/light_bar_pattern_sequencer_unit.sv -----
// Top level of the light bar pattern sequencer: input stage, state and result register.
// Depends on lbps_pkg and lbps_step.
//
//   channel   signals                        direction   meaning
//   in        in_valid, in_stall, button_level   sink     one millisecond tick
//   out       out_valid, out_stall, lamps, mode  source   lamp state for that tick
//   cfg       cfg_valid, cfg_ready, debounce_ms  sink     debounce register write
//
// One tick is accepted every cycle while in_stall is low.
// The tick's work is one pass through lbps_step between the s1 stage and the result register.
// Reset: mode off, button released, counters zero, debounce 180.
// A stalled result holds the s1 stage, which then stalls the input.
module light_bar_pattern_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            button_level,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbps_pkg::DEBOUNCE_W-1:0] debounce_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            head_left,
	output logic                            head_right,
	output logic                            tail_left,
	output logic                            tail_right,
	output logic [1:0]                      amber_left,
	output logic [1:0]                      amber_right,
	output logic [3:0]                      red_bar,
	output logic [3:0]                      blue_bar,
	output logic [lbps_pkg::MODE_W-1:0]     current_mode
);
	import lbps_pkg::*;

	lbps_state_t           state_q;
	lbps_state_t           state_next;
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic                  valid_s1;
	logic                  button_s1;
	logic                  out_valid_q;
	logic [LAMPS_W-1:0]    lamps_next;
	logic [LAMPS_W-1:0]    lamps_q;
	logic [MODE_W-1:0]     mode_out_q;
	logic                  out_free;
	logic                  advance;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	lbps_step u_step (
		.state        (state_q),
		.button_level (button_s1),
		.debounce_ms  (debounce_q),
		.state_next   (state_next),
		.lamps        (lamps_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			debounce_q  <= DEBOUNCE_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				debounce_q <= debounce_ms;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_level;
		end
		if (advance) begin
			lamps_q    <= lamps_next;
			mode_out_q <= state_next.mode;
		end
	end

	assign out_valid    = out_valid_q;
	assign head_left    = lamps_q[0];
	assign head_right   = lamps_q[1];
	assign tail_left    = lamps_q[2];
	assign tail_right   = lamps_q[3];
	assign amber_left   = lamps_q[5:4];
	assign amber_right  = lamps_q[7:6];
	assign red_bar      = lamps_q[11:8];
	assign blue_bar     = lamps_q[15:12];
	assign current_mode = mode_out_q;

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode <= MODE_LAST)
		else $error("mode out of range");

	a_static_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode <= MODE_STATIC) |-> (state_q.step_index == '0 && state_q.step_timer == '0))
		else $error("static mode with running pattern");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode > MODE_STATIC) |-> (state_q.step_index < mode_len(state_q.mode)))
		else $error("step index past end of table");

	a_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_next.mode != state_q.mode) |=> (state_q.since_press == '0))
		else $error("accepted press did not clear counter");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> $stable(state_q))
		else $error("state moved during stall");

endmodule
